FILE: design/wavetable_sound_generator_macros.svh
// Assertion macros for the wavetable sound generator.
// Depends on signals named clk and rst_n in the including module.
`ifndef WAVETABLE_SOUND_GENERATOR_MACROS_SVH
`define WAVETABLE_SOUND_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define WSG_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define WSG_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define WSG_ASSERT_NOW(lbl, pre, post, msg)
`define WSG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: design/wsg_pkg.sv
// Shared types and constants of the wavetable sound generator.
// No dependencies.
package wsg_pkg;
  localparam int FRACTION_BITS_DEF = 22;
  localparam int NUM_CH = 5;
  localparam int CH_W = 3;
  localparam int RAM_DEPTH = 160;
  localparam int RAM_AW = 8;
  localparam int DIV_W = 32;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] MODE_ORIG = 2'd0;
  localparam logic [1:0] MODE_COMPAT = 2'd1;
  localparam logic [1:0] MODE_EXT = 2'd2;

  localparam logic [1:0] CFG_CHIP_MODE = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_STEP = 2'd1;
  localparam logic [1:0] CFG_CHIP_STEP = 2'd2;

  localparam logic [31:0] OUTPUT_STEP_RST = 32'd48695;
  localparam logic [31:0] CHIP_STEP_RST = 32'd1199;
  localparam logic [4:0] ENABLE_RST = 5'h1f;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] address;
    logic [7:0] write_data;
  } wsg_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [14:0] sample_out;
  } wsg_out_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic wr;
    logic mirror;
    logic div_start_p;
    logic div_store_p;
    logic rd_addr;
    logic rd_cap;
    logic mix_rd;
    logic mix_acc;
    logic ch_inc;
    logic ch_clr;
    logic rate;
    logic div_store_r;
    logic ph_mul;
    logic ph_add;
  } wsg_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic clr_last;
    logic need_mirror;
    logic need_div;
    logic rate_lt;
    logic div_done;
    logic ch_last;
  } wsg_stat_t;
endpackage

FILE: design/wsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/wsg_div.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies.
module wsg_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);
  localparam int CNT_W = $clog2(W);

  logic [W-1:0] quo_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic run_r, done_r;
  logic [W:0] shifted, diff;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (!diff[W]) begin
          rem_r <= diff[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = quo_r;
  assign remainder = rem_r;
endmodule

FILE: design/wsg_ctrl.sv
// Sequencer of the wavetable sound generator.
// Depends on wsg_pkg.
module wsg_ctrl
  import wsg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  wsg_stat_t st,
  output wsg_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_WRITE, S_MIRROR, S_DIVP, S_READ, S_READ_CAP,
    S_MIX_RD, S_MIX_ACC, S_RATE, S_DIVR, S_PH_MUL, S_PH_ADD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.func)
          FUNC_WRITE: state_nxt = S_WRITE;
          FUNC_READ:  state_nxt = S_READ;
          FUNC_TICK:  state_nxt = S_MIX_RD;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        if (st.need_mirror) begin
          state_nxt = S_MIRROR;
        end else if (st.need_div) begin
          cmd.div_start_p = 1'b1;
          state_nxt = S_DIVP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MIRROR: begin
        cmd.mirror = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIVP: begin
        if (st.div_done) begin
          cmd.div_store_p = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_READ: begin
        cmd.rd_addr = 1'b1;
        state_nxt = S_READ_CAP;
      end
      S_READ_CAP: begin
        cmd.rd_cap = 1'b1;
        state_nxt = S_OUT;
      end
      S_MIX_RD: begin
        cmd.mix_rd = 1'b1;
        state_nxt = S_MIX_ACC;
      end
      S_MIX_ACC: begin
        cmd.mix_acc = 1'b1;
        if (st.ch_last) begin
          cmd.ch_clr = 1'b1;
          state_nxt = S_RATE;
        end else begin
          cmd.ch_inc = 1'b1;
          state_nxt = S_MIX_RD;
        end
      end
      S_RATE: begin
        cmd.rate = 1'b1;
        state_nxt = st.rate_lt ? S_DIVR : S_PH_MUL;
      end
      S_DIVR: begin
        if (st.div_done) begin
          cmd.div_store_r = 1'b1;
          state_nxt = S_PH_MUL;
        end
      end
      S_PH_MUL: begin
        cmd.ph_mul = 1'b1;
        state_nxt = S_PH_ADD;
      end
      S_PH_ADD: begin
        cmd.ph_add = 1'b1;
        if (st.ch_last) begin
          state_nxt = S_OUT;
        end else begin
          cmd.ch_inc = 1'b1;
          state_nxt = S_PH_MUL;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;
  assign out_valid = (state_r == S_OUT);
endmodule

FILE: design/wsg_dp.sv
// Datapath: register map, wave RAM, channel state, mixer and rate converter.
// Depends on wsg_pkg, wsg_ram and wsg_div.
module wsg_dp
  import wsg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  wsg_in_t     in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  wsg_cmd_t    cmd,
  output wsg_stat_t   st,
  output wsg_out_t    res
);
  localparam logic [DIV_W-1:0] INCR_NUM = DIV_W'(1) << (FRACTION_BITS + 1);

  logic [1:0] mode_r, mode;
  logic [31:0] out_step_r, chip_step_r, rate_time_r, cs;
  wsg_in_t in_r;
  wsg_out_t res_r;
  logic [11:0] period_r [NUM_CH];
  logic [3:0] vol_r [NUM_CH];
  logic [31:0] acc_r [NUM_CH];
  logic [31:0] incr_r [NUM_CH];
  logic [4:0] enable_r;
  logic [7:0] deform_r;
  logic [CH_W-1:0] ch_r, wr_ch;
  logic [RAM_AW-1:0] clr_r;
  logic [31:0] n_r, prod_r;

  logic [7:0] a;
  logic wr_wave, wr_mirror, wr_fv, wr_deform, fv_period;
  logic [11:0] new_period, p_eff;
  logic [2:0] vol_idx;
  logic rd_is_wave;
  logic [RAM_AW-1:0] rd_wave_addr, ram_waddr, ram_raddr;
  logic [7:0] rd_byte, fv_byte, ram_q;
  logic ram_we;
  logic [11:0] mix_prod;
  logic rate_lt, div_start, div_done;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_rem;

  assign mode = (mode_r == MODE_EXT || mode_r == MODE_COMPAT) ? mode_r : MODE_ORIG;
  assign a = in_r.address;
  assign wr_ch = a[3:1];
  assign vol_idx = 3'(a[3:0] - 4'd10);
  assign fv_period = (a[3:0] < 4'd10);
  assign cs = (chip_step_r == 32'd0) ? 32'd1 : chip_step_r;
  assign rate_lt = (rate_time_r < out_step_r);

  always_comb begin
    wr_wave = 1'b0;
    wr_mirror = 1'b0;
    wr_fv = 1'b0;
    wr_deform = 1'b0;
    if (mode == MODE_EXT) begin
      wr_wave = (a < 8'hA0);
      wr_fv = (a[7:5] == 3'b101);
      wr_deform = (a[7:5] == 3'b110);
    end else begin
      wr_wave = !a[7];
      wr_mirror = !a[7] && (a[6:5] == 2'b11);
      wr_fv = (a[7:5] == 3'b100);
      wr_deform = (mode == MODE_ORIG) ? (a[7:5] == 3'b111) : (a[7:5] == 3'b110);
    end
  end

  always_comb begin
    new_period = 12'd0;
    if (fv_period) begin
      if (a[0]) new_period = {in_r.write_data[3:0], period_r[wr_ch][7:0]};
      else new_period = {period_r[wr_ch][11:8], in_r.write_data};
    end
    p_eff = new_period;
    if (deform_r[1]) p_eff = p_eff & 12'h0FF;
    if (deform_r[0]) p_eff = p_eff >> 8;
  end

  always_comb begin
    if (fv_period) begin
      fv_byte = a[0] ? {4'd0, period_r[wr_ch][11:8]} : period_r[wr_ch][7:0];
    end else if (a[3:0] < 4'd15) begin
      fv_byte = {4'd0, vol_r[vol_idx]};
    end else begin
      fv_byte = {3'd0, enable_r};
    end
  end

  always_comb begin
    rd_is_wave = 1'b0;
    rd_wave_addr = {3'd4, a[4:0]};
    rd_byte = 8'hFF;
    if (!a[7]) begin
      rd_is_wave = 1'b1;
      rd_wave_addr = a;
    end else if (mode == MODE_ORIG || a >= 8'hE0) begin
      rd_byte = 8'hFF;
    end else if (a >= 8'hC0) begin
      rd_byte = deform_r;
    end else if (mode == MODE_COMPAT) begin
      if (a < 8'hA0) rd_byte = fv_byte;
      else rd_is_wave = 1'b1;
    end else begin
      if (a < 8'hA0) rd_is_wave = 1'b1;
      else rd_byte = fv_byte;
    end
  end

  assign ram_we = cmd.clr || (cmd.wr && wr_wave) || cmd.mirror;
  assign ram_waddr = cmd.clr ? clr_r : (cmd.mirror ? {3'd4, a[4:0]} : a);
  assign ram_raddr = cmd.mix_rd ? {ch_r, acc_r[ch_r][FRACTION_BITS +: 5]} : rd_wave_addr;

  wsg_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr),
    .wdata(cmd.clr ? 8'd0 : in_r.write_data),
    .raddr(ram_raddr), .rdata(ram_q)
  );

  assign div_start = cmd.div_start_p || (cmd.rate && rate_lt);
  assign div_a = cmd.rate ? (out_step_r - rate_time_r) : INCR_NUM;
  assign div_b = cmd.rate ? cs : DIV_W'(p_eff) + DIV_W'(1);

  wsg_div #(.W(DIV_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  assign mix_prod = ram_q * vol_r[ch_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ORIG;
      out_step_r <= OUTPUT_STEP_RST;
      chip_step_r <= CHIP_STEP_RST;
      rate_time_r <= '0;
      enable_r <= ENABLE_RST;
      deform_r <= '0;
      ch_r <= '0;
      clr_r <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        period_r[i] <= '0;
        vol_r[i] <= '0;
        acc_r[i] <= '0;
        incr_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHIP_MODE:   mode_r <= cfg_wdata[1:0];
          CFG_OUTPUT_STEP: out_step_r <= cfg_wdata;
          CFG_CHIP_STEP:   chip_step_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.latch || cmd.ch_clr) ch_r <= '0;
      else if (cmd.ch_inc) ch_r <= ch_r + 1'b1;
      if (cmd.wr) begin
        if (wr_deform) deform_r <= in_r.write_data;
        if (wr_fv) begin
          if (fv_period) begin
            period_r[wr_ch] <= new_period;
            if (deform_r[5]) acc_r[wr_ch] <= '0;
            if (p_eff <= 12'd8) incr_r[wr_ch] <= '0;
          end else if (a[3:0] < 4'd15) begin
            vol_r[vol_idx] <= in_r.write_data[3:0];
          end else begin
            enable_r <= in_r.write_data[4:0];
          end
        end
      end
      if (cmd.div_store_p) incr_r[wr_ch] <= div_q;
      if (cmd.rate && !rate_lt) begin
        rate_time_r <= rate_time_r - out_step_r;
        n_r <= '0;
      end
      if (cmd.div_store_r) begin
        n_r <= (div_rem != '0) ? div_q + 32'd1 : div_q;
        rate_time_r <= (div_rem != '0) ? cs - div_rem : 32'd0;
      end
      if (cmd.ph_mul) prod_r <= 32'(n_r * incr_r[ch_r]);
      if (cmd.ph_add) acc_r[ch_r] <= acc_r[ch_r] + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_r <= in_data;
      res_r <= '0;
    end
    if (cmd.rd_cap) res_r.read_data <= rd_is_wave ? ram_q : rd_byte;
    if (cmd.mix_acc && enable_r[ch_r]) res_r.sample_out <= res_r.sample_out + 15'(mix_prod);
  end

  assign st.func = in_r.func;
  assign st.clr_last = (clr_r == RAM_AW'(RAM_DEPTH - 1));
  assign st.need_mirror = wr_mirror;
  assign st.need_div = wr_fv && fv_period && (p_eff > 12'd8);
  assign st.rate_lt = rate_lt;
  assign st.div_done = div_done;
  assign st.ch_last = (ch_r == CH_W'(NUM_CH - 1));
  assign res = res_r;
endmodule

FILE: design/wavetable_sound_generator.sv
// Top level of the five-channel wavetable sound generator.
// Depends on wsg_pkg, wsg_ctrl, wsg_dp and the assertion macro header.
//
// Usage: drive in_data and raise start; the command transfers at a clock edge where
// start is high and busy is low. Commands are register writes, register reads and
// sample ticks. Each command yields exactly one result on out_data, shown for one
// cycle with out_valid high; the receiver cannot stall it.
// The route from transfer to result depends on the command: the unused function code,
// a write, a wave-four mirrored write, a period write (which waits on the shared
// divider), a read, and a sample tick (five RAM reads, an optional divide for the rate
// converter, five multiply-add steps) each pass through their own sequencer states.
// One command is in flight at a time; busy returns low the cycle after the result, so
// the next transfer can come only after the result cycle.
// Reset is synchronous, active low. After reset the block clears all 160 wave RAM
// entries, one entry a cycle, with busy high. Configuration writes through cfg_we,
// cfg_index and cfg_wdata take effect at once; the user must make them only while
// idle, as the block itself does not enforce this.
`include "wavetable_sound_generator_macros.svh"
module wavetable_sound_generator
  import wsg_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  wsg_in_t     in_data,
  output logic        out_valid,
  output wsg_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  wsg_cmd_t cmd;
  wsg_stat_t st;

  wsg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd),
    .busy(busy), .out_valid(out_valid)
  );

  wsg_dp #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .cmd(cmd), .st(st), .res(out_data)
  );

  `WSG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `WSG_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `WSG_ASSERT_NOW(a_result_busy, out_valid, busy, "result shown while idle")
  `WSG_ASSERT_NOW(a_one_field, out_valid,
                  out_data.read_data == 8'd0 || out_data.sample_out == 15'd0,
                  "both result fields nonzero")
endmodule
